// ===== design/midpoint_local_threshold_assert.svh =====
// Assertion macros for the midpoint threshold block.
`ifndef MIDPOINT_LOCAL_THRESHOLD_ASSERT_SVH
`define MIDPOINT_LOCAL_THRESHOLD_ASSERT_SVH
`ifndef SYNTHESIS
`define MLT_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error(msg);
`define MLT_ASSERT_NEVER(lbl, ck, rstn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) \
		else $error(msg);
`else
`define MLT_ASSERT(lbl, ck, rstn, prop, msg)
`define MLT_ASSERT_NEVER(lbl, ck, rstn, cond, msg)
`endif
`endif

// ===== design/mlt_pkg.sv =====
`timescale 1ns / 1ps
package mlt_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 3;
	localparam int LS_ROWS    = 2 * MAX_RADIUS + 3;
	localparam int WIN        = 2 * MAX_RADIUS + 1;
	localparam int FIFO_DEPTH = 8;
	localparam int CFG_W      = 11;
	localparam int RAD_W      = 2;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
	localparam int SLOT_W     = $clog2(LS_ROWS);
	localparam int WPOS_W     = $clog2(WIN);
	localparam int WCNT_W     = $clog2(WIN + 1);
	localparam int NRD_W      = $clog2(MAX_RADIUS + 2);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam logic [PIX_W-1:0] PIX_WHITE = '1;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             drain;
	} pix_in_t;

	typedef struct packed {
		logic white;
		logic last_of_frame;
	} res_out_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  slot;
		logic [COL_W-1:0]   col;
		logic [PIX_W-1:0]   data;
	} wr_req_t;

	typedef struct packed {
		logic               valid;
		logic [COL_W-1:0]   col;
		logic [LS_ROWS-1:0] mask;
		logic [SLOT_W-1:0]  cslot;
	} rd_req_t;

	typedef struct packed {
		logic              valid;
		logic [WPOS_W-1:0] pos;
		logic [WCNT_W-1:0] cnt;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic [PIX_W-1:0] mn;
		logic [PIX_W-1:0] mx;
		logic [PIX_W-1:0] ctr;
	} col_agg_t;
endpackage

// ===== design/mlt_line_store.sv =====
`timescale 1ns / 1ps
module mlt_line_store import mlt_pkg::*; (
	input  logic                          clk,
	input  wr_req_t                       wr,
	input  logic [COL_W-1:0]              rd_col,
	output logic [LS_ROWS-1:0][PIX_W-1:0] rdata
);
	for (genvar j = 0; j < LS_ROWS; j++) begin : g_row
		logic [PIX_W-1:0] mem [MAX_WIDTH];
		logic [PIX_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (wr.en && (wr.slot == SLOT_W'(j))) begin
				mem[wr.col] <= wr.data;
			end
			rd_q <= mem[rd_col];
		end

		assign rdata[j] = rd_q;
	end
endmodule

// ===== design/mlt_window.sv =====
`timescale 1ns / 1ps
module mlt_window import mlt_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rd_req_t                       rd,
	input  wr_req_t                       wr,
	input  logic [LS_ROWS-1:0][PIX_W-1:0] rdata,
	input  tok_t                          tok,
	output logic                          res_valid,
	output res_out_t                      res
);
	rd_req_t  rd_s2;
	wr_req_t  wr_s2;
	tok_t     tok_s2;
	tok_t     tok_s3;
	col_agg_t col_agg;
	col_agg_t win_q [WIN];
	logic [PIX_W-1:0] win_mn;
	logic [PIX_W-1:0] win_mx;
	logic [PIX_W:0]   mid_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2  <= '0;
			wr_s2  <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
		end else begin
			rd_s2  <= rd;
			wr_s2  <= wr;
			tok_s2 <= tok;
			tok_s3 <= tok_s2;
		end
	end

	// merge the row written in the same cycle as the read
	always_comb begin
		logic [PIX_W-1:0] v;
		col_agg.mn  = PIX_WHITE;
		col_agg.mx  = '0;
		col_agg.ctr = '0;
		for (int j = 0; j < LS_ROWS; j++) begin
			v = rdata[j];
			if (wr_s2.en && (wr_s2.slot == SLOT_W'(j)) && (wr_s2.col == rd_s2.col)) begin
				v = wr_s2.data;
			end
			if (rd_s2.mask[j]) begin
				if (v < col_agg.mn) col_agg.mn = v;
				if (v > col_agg.mx) col_agg.mx = v;
			end
			if (rd_s2.cslot == SLOT_W'(j)) col_agg.ctr = v;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s2.valid) begin
			win_q[0] <= col_agg;
			for (int k = 1; k < WIN; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	always_comb begin
		win_mn = PIX_WHITE;
		win_mx = '0;
		for (int k = 0; k < WIN; k++) begin
			if (WCNT_W'(k) < tok_s3.cnt) begin
				if (win_q[k].mn < win_mn) win_mn = win_q[k].mn;
				if (win_q[k].mx > win_mx) win_mx = win_q[k].mx;
			end
		end
	end

	assign mid_sum           = {1'b0, win_mx} + {1'b0, win_mn};
	assign res_valid         = tok_s3.valid;
	assign res.white         = win_q[tok_s3.pos].ctr > mid_sum[PIX_W:1];
	assign res.last_of_frame = tok_s3.last;
endmodule

// ===== design/mlt_out_fifo.sv =====
`timescale 1ns / 1ps
module mlt_out_fifo import mlt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  res_out_t din,
	input  logic     pop,
	output logic     valid,
	output res_out_t dout
);
	res_out_t          mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FCNT_W'(push) - FCNT_W'(pop);
		end
	end

	assign valid = cnt_q != '0;
	assign dout  = mem_q[rd_ptr_q];
endmodule

// ===== design/midpoint_local_threshold.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | pix_in_t  (pixel, drain)
// out     | output    | out_valid/out_stall| res_out_t (white, last_of_frame)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock unless a row-start fetch or lack of FIFO credit holds the input.
// The first result of each row reads up to radius+1 columns of the line store through
// its single read port. After its last column read, a result passes tok_s2 and tok_s3.
// Reset clears counters and control; the line store is not cleared.
// Output stalls back up through an eight-entry FIFO and its credit count.
`include "midpoint_local_threshold_assert.svh"
module midpoint_local_threshold import mlt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pix_in_t          in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output res_out_t         out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [RAD_W-1:0]  radius_q;
	logic [CNT_W-1:0]  eff_w;
	logic [ROW_W-1:0]  eff_h;
	logic [RAD_W-1:0]  eff_r;
	logic              cfg_hit;

	pix_in_t           s1_q;
	logic              s1_valid_q;
	logic              fire;
	logic              pop;
	logic [FCNT_W-1:0] used_q;

	logic [CNT_W-1:0]  in_col_q, out_col_q, in_col_n, in_col_inc;
	logic [ROW_W-1:0]  in_row_q, out_row_q, in_row_n;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q, in_slot_n;
	logic              wr_ok;

	logic [ROW_W:0]    ry_sum, ry_lim;
	logic [CNT_W:0]    rx_sum, rx_lim;
	logic [ROW_W-1:0]  ry;
	logic [CNT_W-1:0]  rx;
	logic              ready, tok, last;
	logic [RAD_W-1:0]  dy, dx;
	logic [ROW_W-1:0]  ny_full;
	logic [WCNT_W-1:0] ny;
	logic [SLOT_W:0]   s0_sum, s0;
	logic [LS_ROWS-1:0] mask;
	logic [NRD_W-1:0]  nrd;
	logic [COL_W-1:0]  cs;
	tok_t              new_tok;

	logic              busy_q;
	logic [NRD_W-1:0]  frem_q;
	logic [COL_W-1:0]  fcol_q;
	logic [LS_ROWS-1:0] fmask_q;
	logic [SLOT_W-1:0] fcslot_q;
	tok_t              ftok_q;
	rd_req_t           rd_req;
	tok_t              tok_go;
	wr_req_t           wr_req;

	logic [LS_ROWS-1:0][PIX_W-1:0] rdata;
	logic              res_valid;
	res_out_t          res;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && cfg_ready && ((cfg_index == REG_WIDTH) ||
		(cfg_index == REG_HEIGHT) || (cfg_index == REG_RADIUS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
			radius_q <= RAD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) eff_w = CNT_W'(1);
		else if (32'(width_q) > MAX_WIDTH) eff_w = CNT_W'(MAX_WIDTH);
		else eff_w = CNT_W'(width_q);
		if (height_q == '0) eff_h = ROW_W'(1);
		else if (32'(height_q) > MAX_HEIGHT) eff_h = ROW_W'(MAX_HEIGHT);
		else eff_h = ROW_W'(height_q);
		if (32'(radius_q) > MAX_RADIUS) eff_r = RAD_W'(MAX_RADIUS);
		else eff_r = radius_q;
	end

	// input register
	assign pop      = out_valid && !out_stall;
	assign fire     = s1_valid_q && !busy_q && (used_q < FCNT_W'(FIFO_DEPTH));
	assign in_stall = s1_valid_q && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) s1_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) used_q <= '0;
		else used_q <= used_q + FCNT_W'(tok) - FCNT_W'(pop);
	end

	// frame position
	assign wr_ok      = !s1_q.drain && (in_row_q < eff_h);
	assign in_col_inc = in_col_q + 1'b1;

	always_comb begin
		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		in_slot_n = in_slot_q;
		if (wr_ok) begin
			if (in_col_inc >= eff_w) begin
				in_col_n  = '0;
				in_row_n  = in_row_q + 1'b1;
				in_slot_n = (in_slot_q == SLOT_W'(LS_ROWS - 1)) ? '0 : in_slot_q + 1'b1;
			end else begin
				in_col_n = in_col_inc;
			end
		end
	end

	always_comb begin
		ry_sum = {1'b0, out_row_q} + (ROW_W+1)'(eff_r);
		ry_lim = {1'b0, eff_h - 1'b1};
		ry     = (ry_sum > ry_lim) ? ry_lim[ROW_W-1:0] : ry_sum[ROW_W-1:0];
		rx_sum = {1'b0, out_col_q} + (CNT_W+1)'(eff_r);
		rx_lim = {1'b0, eff_w - 1'b1};
		rx     = (rx_sum > rx_lim) ? rx_lim[CNT_W-1:0] : rx_sum[CNT_W-1:0];
		ready  = (out_row_q < eff_h) &&
			((in_row_n > ry) || ((in_row_n == ry) && (in_col_n > rx)));
		last   = (out_row_q == eff_h - 1'b1) && (out_col_q == eff_w - 1'b1);
		dy     = (out_row_q < ROW_W'(eff_r)) ? out_row_q[RAD_W-1:0] : eff_r;
		dx     = (out_col_q < CNT_W'(eff_r)) ? out_col_q[RAD_W-1:0] : eff_r;
		ny_full = ry - (out_row_q - ROW_W'(dy)) + 1'b1;
		ny     = ny_full[WCNT_W-1:0];
		s0_sum = {1'b0, out_slot_q} + (SLOT_W+1)'(LS_ROWS) - (SLOT_W+1)'(dy);
		s0     = (s0_sum >= (SLOT_W+1)'(LS_ROWS)) ? s0_sum - (SLOT_W+1)'(LS_ROWS) : s0_sum;
		new_tok.valid = 1'b1;
		new_tok.pos   = WPOS_W'(rx - out_col_q);
		new_tok.cnt   = WCNT_W'(rx - (out_col_q - CNT_W'(dx)) + 1'b1);
		new_tok.last  = last;
		if (out_col_q == '0) begin
			nrd = NRD_W'(rx) + 1'b1;
			cs  = '0;
		end else if (rx_sum <= rx_lim) begin
			nrd = NRD_W'(1);
			cs  = rx_sum[COL_W-1:0];
		end else begin
			nrd = '0;
			cs  = '0;
		end
	end

	always_comb begin
		logic [SLOT_W:0] off;
		for (int j = 0; j < LS_ROWS; j++) begin
			off = (SLOT_W+1)'(j) + (SLOT_W+1)'(LS_ROWS) - s0;
			if (off >= (SLOT_W+1)'(LS_ROWS)) off = off - (SLOT_W+1)'(LS_ROWS);
			mask[j] = off < (SLOT_W+1)'(ny);
		end
	end

	assign tok = fire && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else if (cfg_hit) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else if (fire) begin
			in_col_q  <= in_col_n;
			in_row_q  <= in_row_n;
			in_slot_q <= in_slot_n;
			if (tok) begin
				if (last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
				end else if (out_col_q + 1'b1 >= eff_w) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + 1'b1;
					out_slot_q <= (out_slot_q == SLOT_W'(LS_ROWS - 1)) ? '0 :
						out_slot_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// column fetch
	always_comb begin
		rd_req = '0;
		tok_go = '0;
		if (busy_q) begin
			rd_req.valid = 1'b1;
			rd_req.col   = fcol_q;
			rd_req.mask  = fmask_q;
			rd_req.cslot = fcslot_q;
			if (frem_q == NRD_W'(1)) tok_go = ftok_q;
		end else if (tok) begin
			if (nrd != '0) begin
				rd_req.valid = 1'b1;
				rd_req.col   = cs;
				rd_req.mask  = mask;
				rd_req.cslot = out_slot_q;
				if (nrd == NRD_W'(1)) tok_go = new_tok;
			end else begin
				tok_go = new_tok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			frem_q   <= '0;
			fcol_q   <= '0;
			fmask_q  <= '0;
			fcslot_q <= '0;
			ftok_q   <= '0;
		end else if (busy_q) begin
			if (frem_q == NRD_W'(1)) busy_q <= 1'b0;
			frem_q <= frem_q - 1'b1;
			fcol_q <= fcol_q + 1'b1;
		end else if (tok && (nrd > NRD_W'(1))) begin
			busy_q   <= 1'b1;
			frem_q   <= nrd - 1'b1;
			fcol_q   <= cs + 1'b1;
			fmask_q  <= mask;
			fcslot_q <= out_slot_q;
			ftok_q   <= new_tok;
		end
	end

	assign wr_req.en   = fire && wr_ok;
	assign wr_req.slot = in_slot_q;
	assign wr_req.col  = in_col_q[COL_W-1:0];
	assign wr_req.data = s1_q.pixel;

	mlt_line_store u_line_store (
		.clk    (clk),
		.wr     (wr_req),
		.rd_col (rd_req.col),
		.rdata  (rdata)
	);

	mlt_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd_req),
		.wr        (wr_req),
		.rdata     (rdata),
		.tok       (tok_go),
		.res_valid (res_valid),
		.res       (res)
	);

	mlt_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.pop    (pop),
		.valid  (out_valid),
		.dout   (out_data)
	);

	`MLT_ASSERT(a_credit_bound, clk, arst_n, used_q <= FCNT_W'(FIFO_DEPTH), "credit overflow")
	`MLT_ASSERT(a_out_has_credit, clk, arst_n, out_valid |-> (used_q != '0), "result without credit")
	`MLT_ASSERT(a_row_start_fetch, clk, arst_n, (tok && (nrd > NRD_W'(1))) |=> busy_q, "row start fetch lost")
	`MLT_ASSERT_NEVER(a_out_row_range, clk, arst_n, out_row_q >= eff_h, "result row outside frame")
endmodule
